FILE: design/huffman_tree_bit_decoder_top_macros.svh
// Assertion macros of the decoder, used by the controller.
// Define ASSERT_OFF to compile every check away.
`ifndef HUFFMAN_TREE_BIT_DECODER_TOP_MACROS_SVH
`define HUFFMAN_TREE_BIT_DECODER_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// Check on every clock edge outside reset.
`define HTBD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check on every clock edge, reset included.
`define HTBD_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define HTBD_ASSERT(lbl, clk, rstn, prop, msg)

`define HTBD_ASSERT_NR(lbl, clk, prop, msg)

`endif

`endif

FILE: design/htbd_pkg.sv
// Shared types and codes of the tree bit decoder.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps

package htbd_pkg;

  // Input action codes
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_DATA = 1'b1;

  // Result kind codes
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Leaf symbols at or above this value end the stream
  localparam int unsigned SYMBOL_LIMIT = 256;

  localparam int unsigned NODE_COUNT_W = 9;
  localparam int unsigned CHILD_W      = 16;
  localparam int unsigned WORD_W       = 2 * CHILD_W;
  localparam int unsigned BIT_CNT_W    = 3;

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // write one tree node
    logic start;  // take a data byte
    logic step;   // walk one bit
    logic fin;    // final-byte check
    logic flush;  // hand the held result out as the last one
  } htbd_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic sticky_err;
    logic ended;
    logic step_result;
    logic step_done;
    logic fin_result;
    logic pend_valid;
    logic slot_free;
  } htbd_sts_t;

endpackage

FILE: design/huffman_tree_bit_decoder_top.sv
// Top level of the tree bit decoder: sequencer plus datapath with tree memory.
// Depends on htbd_pkg, htbd_ctrl, htbd_datapath and htbd_ram.
// Load transaction writes one tree node. Data byte: taken, then walked with one tree-memory
// read per bit (stopping early on end or error), then the final check, then the flush.
// A byte taken under a sticky error goes straight to the flush; one taken after the end gives no result.
// Reset clears control, node_count to 1; the tree memory is not cleared.
`timescale 1ns / 1ps

module huffman_tree_bit_decoder_top #(
  parameter int unsigned MAX_NODES = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration: node_count
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [htbd_pkg::NODE_COUNT_W-1:0] cfg_data_i,
  // input transactions
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              action_i,
  input  logic [7:0]                        node_index_i,
  input  logic signed [15:0]                child_zero_i,
  input  logic signed [15:0]                child_one_i,
  input  logic [7:0]                        data_byte_i,
  input  logic                              final_byte_i,
  // result transactions
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [7:0]                        symbol_o,
  output logic [1:0]                        kind_o,
  output logic                              last_o
);
  import htbd_pkg::*;

  htbd_cmd_t cmd;
  htbd_sts_t sts;

  // Configuration must be written only while idle; the block does not enforce this, so always take it.
  assign cfg_ready_o = 1'b1;

  // Sequencer: takes input transactions only while idle, then steps the
  // walk one bit per cycle and stalls when a new result finds the output register busy.
  htbd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .action_i   (action_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: tree memory, walk state, one held result and the output
  // register. A result is held back until the next one or the end of the
  // byte shows whether it is the last.
  htbd_datapath #(
    .MAX_NODES (MAX_NODES)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_valid_i & cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .node_index_i (node_index_i),
    .child_zero_i (child_zero_i),
    .child_one_i  (child_one_i),
    .data_byte_i  (data_byte_i),
    .final_byte_i (final_byte_i),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .symbol_o     (symbol_o),
    .kind_o       (kind_o),
    .last_o       (last_o)
  );

endmodule

FILE: design/htbd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; read data holds while no read is issued.
`timescale 1ns / 1ps

module htbd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/htbd_ctrl.sv
// Sequencer of the tree bit decoder: input handshake, walk, final check, flush.
// Depends on htbd_pkg and the assertion macros header.
`timescale 1ns / 1ps

module htbd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                action_i,
  input  htbd_pkg::htbd_sts_t sts_i,
  output htbd_pkg::htbd_cmd_t cmd_o
);
  import htbd_pkg::*;
`include "huffman_tree_bit_decoder_top_macros.svh"

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_WALK   = 4'b0010,
    ST_FINCHK = 4'b0100,
    ST_FLUSH  = 4'b1000
  } htbd_state_e;

  htbd_state_e state_q, state_d;
  logic        in_accept;
  logic        walk_go;
  logic        fin_go;
  logic        flush_go;

  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    in_accept  = in_valid_i & in_ready_o;
    // a new result pushes the held one out, so wait for a free output slot
    walk_go  = !(sts_i.step_result && sts_i.pend_valid && !sts_i.slot_free);
    fin_go   = !(sts_i.fin_result && sts_i.pend_valid && !sts_i.slot_free);
    flush_go = !sts_i.pend_valid || sts_i.slot_free;
    cmd_o    = '0;
    state_d  = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (action_i == ACT_LOAD) begin
            cmd_o.load = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            if (sts_i.sticky_err) begin
              state_d = ST_FLUSH;
            end else if (!sts_i.ended) begin
              state_d = ST_WALK;
            end
          end
        end
      end
      ST_WALK: begin
        if (walk_go) begin
          cmd_o.step = 1'b1;
          if (sts_i.step_done) begin
            state_d = ST_FINCHK;
          end
        end
      end
      ST_FINCHK: begin
        if (fin_go) begin
          cmd_o.fin = 1'b1;
          state_d   = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (flush_go) begin
          cmd_o.flush = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `HTBD_ASSERT(a_walk_stall_holds, clk_i, rst_ni, (state_q == ST_WALK && sts_i.step_result && sts_i.pend_valid && !sts_i.slot_free) |=> (state_q == ST_WALK), "walk left while a result was stalled")
  `HTBD_ASSERT(a_flush_empties, clk_i, rst_ni, (state_q == ST_FLUSH && flush_go) |=> (state_q == ST_IDLE && !sts_i.pend_valid), "flush left a held result behind")
  `HTBD_ASSERT(a_sticky_reports, clk_i, rst_ni, (in_accept && action_i == ACT_DATA && sts_i.sticky_err) |=> (state_q == ST_FLUSH && sts_i.pend_valid), "sticky error byte gave no result")
  `HTBD_ASSERT_NR(a_idle_no_pend, clk_i, sts_i.pend_valid |-> (state_q != ST_IDLE), "held result while idle")

endmodule

FILE: design/htbd_datapath.sv
// Datapath of the tree bit decoder: tree memory, walk registers, result holding.
// Depends on htbd_pkg and htbd_ram.
`timescale 1ns / 1ps

module htbd_datapath #(
  parameter int unsigned MAX_NODES = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  htbd_pkg::htbd_cmd_t               cmd_i,
  output htbd_pkg::htbd_sts_t               sts_o,
  input  logic                              cfg_we_i,
  input  logic [htbd_pkg::NODE_COUNT_W-1:0] cfg_data_i,
  input  logic [7:0]                        node_index_i,
  input  logic signed [15:0]                child_zero_i,
  input  logic signed [15:0]                child_one_i,
  input  logic [7:0]                        data_byte_i,
  input  logic                              final_byte_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [7:0]                        symbol_o,
  output logic [1:0]                        kind_o,
  output logic                              last_o
);
  import htbd_pkg::*;

  localparam int unsigned NAW = $clog2(MAX_NODES);

  logic [NODE_COUNT_W-1:0] node_count_q;
  logic [NAW-1:0]          walk_node_q;
  logic                    ended_q;
  logic                    err_q;
  logic [7:0]              byte_q;
  logic                    fin_q;
  logic [BIT_CNT_W-1:0]    bit_cnt_q;
  logic                    pend_valid_q;
  logic [7:0]              pend_sym_q;
  logic [1:0]              pend_kind_q;
  logic                    out_valid_q;
  logic [7:0]              out_sym_q;
  logic [1:0]              out_kind_q;
  logic                    out_last_q;

  logic                    ram_we;
  logic                    ram_re;
  logic [NAW-1:0]          ram_raddr;
  logic [WORD_W-1:0]       word;
  logic [CHILD_W-1:0]      child;
  logic [CHILD_W-1:0]      leaf_sym;
  logic [CHILD_W-1:0]      lim;
  logic                    is_leaf;
  logic                    is_data;
  logic                    is_bad;
  logic [NAW-1:0]          next_node;
  logic [7:0]              step_sym;
  logic [1:0]              step_kind;
  logic                    fin_result;
  logic                    push;

  // Tree memory: child_zero in the low half, child_one in the high half
  htbd_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_NODES)
  ) u_tree_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (NAW'(node_index_i)),
    .wdata_i ({child_one_i, child_zero_i}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (word)
  );

  always_comb begin
    ram_we = cmd_i.load && (int'(node_index_i) < int'(MAX_NODES));
    child  = byte_q[bit_cnt_q] ? word[WORD_W-1:CHILD_W] : word[CHILD_W-1:0];
    is_leaf  = child[CHILD_W-1];
    leaf_sym = ~child;
    is_data  = (32'(leaf_sym) < SYMBOL_LIMIT);
    // effective node count: saturate to the tree size
    lim = (CHILD_W'(node_count_q) > CHILD_W'(MAX_NODES)) ? CHILD_W'(MAX_NODES)
                                                         : CHILD_W'(node_count_q);
    is_bad    = !is_leaf && (child >= lim);
    next_node = is_leaf ? '0 : NAW'(child);
    ram_re    = cmd_i.start || cmd_i.step;
    ram_raddr = cmd_i.start ? walk_node_q : next_node;

    if (is_leaf && is_data) begin
      step_sym  = leaf_sym[7:0];
      step_kind = KIND_DATA;
    end else if (is_leaf) begin
      step_sym  = '0;
      step_kind = KIND_END;
    end else begin
      step_sym  = '0;
      step_kind = KIND_ERROR;
    end

    fin_result = fin_q && !ended_q && !err_q;
    push = (cmd_i.step && (is_leaf || is_bad) && pend_valid_q)
        || (cmd_i.fin && fin_result && pend_valid_q)
        || (cmd_i.flush && pend_valid_q);

    sts_o.sticky_err  = err_q;
    sts_o.ended       = ended_q;
    sts_o.step_result = is_leaf || is_bad;
    sts_o.step_done   = (bit_cnt_q == '1) || (is_leaf && !is_data) || is_bad;
    sts_o.fin_result  = fin_result;
    sts_o.pend_valid  = pend_valid_q;
    sts_o.slot_free   = !out_valid_q || out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NODE_COUNT_W'(1);
      walk_node_q  <= '0;
      ended_q      <= 1'b0;
      err_q        <= 1'b0;
      bit_cnt_q    <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        node_count_q <= cfg_data_i;
      end
      // a load of the root restarts the stream
      if (cmd_i.load && node_index_i == '0) begin
        walk_node_q <= '0;
        ended_q     <= 1'b0;
        err_q       <= 1'b0;
      end
      if (cmd_i.start) begin
        bit_cnt_q <= '0;
        if (err_q) begin
          pend_valid_q <= 1'b1;
        end
      end
      if (cmd_i.step) begin
        bit_cnt_q <= bit_cnt_q + 1'b1;
        if (is_leaf) begin
          walk_node_q  <= '0;
          pend_valid_q <= 1'b1;
          if (!is_data) begin
            ended_q <= 1'b1;
          end
        end else if (is_bad) begin
          err_q        <= 1'b1;
          pend_valid_q <= 1'b1;
        end else begin
          walk_node_q <= next_node;
        end
      end
      if (cmd_i.fin && fin_result) begin
        err_q        <= 1'b1;
        pend_valid_q <= 1'b1;
      end
      if (cmd_i.flush) begin
        pend_valid_q <= 1'b0;
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      byte_q <= data_byte_i;
      fin_q  <= final_byte_i;
      if (err_q) begin
        pend_sym_q  <= '0;
        pend_kind_q <= KIND_ERROR;
      end
    end
    if (cmd_i.step && (is_leaf || is_bad)) begin
      pend_sym_q  <= step_sym;
      pend_kind_q <= step_kind;
    end
    if (cmd_i.fin && fin_result) begin
      pend_sym_q  <= '0;
      pend_kind_q <= KIND_ERROR;
    end
    if (push) begin
      out_sym_q  <= pend_sym_q;
      out_kind_q <= pend_kind_q;
      out_last_q <= cmd_i.flush;
    end
  end

  assign out_valid_o = out_valid_q;
  assign symbol_o    = out_sym_q;
  assign kind_o      = out_kind_q;
  assign last_o      = out_last_q;

endmodule
